// File: src/ip6ap_pkg.sv
// Shared types, codes and parsing functions for the IPv6 text address parser.
package ip6ap_pkg;

    localparam logic [7:0] CH_DIGIT_LO = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI = 8'h39;
    localparam logic [7:0] CH_LOWER_LO = 8'h61;
    localparam logic [7:0] CH_LOWER_HI = 8'h66;
    localparam logic [7:0] CH_UPPER_LO = 8'h41;
    localparam logic [7:0] CH_UPPER_HI = 8'h46;
    localparam logic [7:0] CH_COLON    = 8'h3a;
    localparam logic [7:0] CH_DOT      = 8'h2e;

    localparam logic [3:0] NUM_GROUPS   = 4'd8;
    localparam logic [2:0] DOTTED_MAX   = 3'd4;
    localparam logic [7:0] OCTET_MAX    = 8'hff;

    typedef enum logic [1:0] {
        RC_NONE,
        RC_DIGIT,
        RC_COLON,
        RC_DOT
    } run_class_t;

    typedef enum logic [2:0] {
        TK_START,
        TK_NUM,
        TK_SEP,
        TK_RALIGN,
        TK_SEP4
    } token_t;

    typedef struct packed {
        run_class_t  run_class;
        logic [2:0]  run_len;
        logic [15:0] hex;
        logic [7:0]  dec;
        logic        dec_bad;
        token_t      prev;
        logic        comp;
        logic [3:0]  lcnt;
        logic [3:0]  rcnt;
        logic [2:0]  dotted;
        logic        err;
    } ctl_t;

    typedef struct packed {
        logic [7:0][15:0] left;
        logic [7:0][15:0] right;
    } grp_t;

    typedef struct packed {
        ctl_t ctl;
        grp_t grp;
    } pstate_t;

    typedef struct packed {
        pstate_t st;
        logic    ok;
    } step_t;

    typedef struct packed {
        logic             ok;
        logic [7:0][15:0] grp;
    } res_t;

    localparam ctl_t CTL_RESET = '{
        run_class: RC_NONE,
        run_len:   3'd0,
        hex:       16'd0,
        dec:       8'd0,
        dec_bad:   1'b0,
        prev:      TK_START,
        comp:      1'b0,
        lcnt:      4'd0,
        rcnt:      4'd0,
        dotted:    3'd0,
        err:       1'b0
    };

    function automatic logic [2:0] run_cap(run_class_t cls);
        logic [2:0] cap;
        unique case (cls)
            RC_DIGIT: cap = 3'd4;
            RC_COLON: cap = 3'd2;
            RC_DOT:   cap = 3'd1;
            default:  cap = 3'd0;
        endcase
        return cap;
    endfunction

    function automatic step_t put_group(pstate_t s, logic [15:0] v);
        step_t r;
        r.st = s;
        r.ok = 1'b1;
        if ((5'(s.ctl.lcnt) + 5'(s.ctl.rcnt)) >= 5'(NUM_GROUPS)) begin
            r.ok = 1'b0;
        end
        else if (s.ctl.comp) begin
            r.st.grp.right[s.ctl.rcnt[2:0]] = v;
            r.st.ctl.rcnt = s.ctl.rcnt + 4'd1;
        end
        else begin
            r.st.grp.left[s.ctl.lcnt[2:0]] = v;
            r.st.ctl.lcnt = s.ctl.lcnt + 4'd1;
        end
        return r;
    endfunction

    function automatic step_t put_octet(pstate_t s);
        step_t r;
        logic [2:0] idx;
        r.st = s;
        r.ok = 1'b1;
        idx = 3'd0;
        if (s.ctl.dec_bad || s.ctl.dec > OCTET_MAX) begin
            r.ok = 1'b0;
        end
        else if (s.ctl.dotted[0]) begin
            r = put_group(s, {s.ctl.dec, 8'h00});
        end
        else if (s.ctl.comp) begin
            if (s.ctl.rcnt == 4'd0) begin
                r.ok = 1'b0;
            end
            else begin
                idx = 3'(s.ctl.rcnt - 4'd1);
                r.st.grp.right[idx] = s.grp.right[idx] | {8'h00, s.ctl.dec};
            end
        end
        else begin
            if (s.ctl.lcnt == 4'd0) begin
                r.ok = 1'b0;
            end
            else begin
                idx = 3'(s.ctl.lcnt - 4'd1);
                r.st.grp.left[idx] = s.grp.left[idx] | {8'h00, s.ctl.dec};
            end
        end
        return r;
    endfunction

    function automatic step_t write_num(pstate_t s);
        step_t r;
        if (s.ctl.dotted != 3'd0) begin
            r = put_octet(s);
        end
        else begin
            r = put_group(s, s.ctl.hex);
        end
        return r;
    endfunction

    // Close the open run as a token.
    function automatic step_t close_run(pstate_t s);
        step_t  r;
        token_t tok;
        r.st = s;
        r.ok = 1'b1;
        tok  = s.ctl.prev;
        case (s.ctl.run_class)
            RC_DIGIT:
            begin
                tok = TK_NUM;
                if (s.ctl.prev == TK_NUM) begin
                    r.ok = 1'b0;
                end
            end
            RC_COLON:
            begin
                if (s.ctl.run_len == 3'd1) begin
                    tok = TK_SEP;
                    if (s.ctl.prev == TK_NUM && s.ctl.dotted == 3'd0) begin
                        r = write_num(s);
                    end
                    else begin
                        r.ok = 1'b0;
                    end
                end
                else begin
                    tok = TK_RALIGN;
                    if (s.ctl.prev == TK_SEP || s.ctl.prev == TK_SEP4 ||
                        s.ctl.dotted != 3'd0 || s.ctl.comp) begin
                        r.ok = 1'b0;
                    end
                    else begin
                        if (s.ctl.prev == TK_NUM) begin
                            r = write_num(s);
                        end
                        r.st.ctl.comp = 1'b1;
                    end
                end
            end
            RC_DOT:
            begin
                tok = TK_SEP4;
                if (s.ctl.prev != TK_NUM || s.ctl.dotted >= DOTTED_MAX) begin
                    r.ok = 1'b0;
                end
                else begin
                    r.st.ctl.dotted = s.ctl.dotted + 3'd1;
                    r = write_num(r.st);
                end
            end
            default:
            begin
                r.ok = 1'b0;
            end
        endcase
        if (s.ctl.run_class != RC_NONE) begin
            r.st.ctl.prev = tok;
        end
        return r;
    endfunction

    // Consume one character into the parser state.
    function automatic pstate_t take_char(pstate_t st, logic [7:0] c);
        pstate_t    s;
        step_t      r;
        run_class_t cls;
        logic [3:0] hv;
        logic [3:0] dv;
        logic       is_dec;
        logic       ok;
        logic [11:0] dmul;
        s      = st;
        cls    = RC_NONE;
        hv     = 4'd0;
        dv     = 4'd0;
        is_dec = 1'b0;
        ok     = 1'b1;
        dmul   = 12'd0;
        if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) begin
            cls    = RC_DIGIT;
            hv     = c[3:0];
            dv     = c[3:0];
            is_dec = 1'b1;
        end
        else if ((c >= CH_LOWER_LO && c <= CH_LOWER_HI) ||
                 (c >= CH_UPPER_LO && c <= CH_UPPER_HI)) begin
            cls = RC_DIGIT;
            hv  = c[3:0] + 4'd9;
        end
        else if (c == CH_COLON) begin
            cls = RC_COLON;
        end
        else if (c == CH_DOT) begin
            cls = RC_DOT;
        end

        if (cls == RC_NONE) begin
            s.ctl.err = 1'b1;
        end
        else begin
            if (s.ctl.run_len != 3'd0 && s.ctl.run_class != cls) begin
                r  = close_run(s);
                s  = r.st;
                ok = r.ok;
                s.ctl.run_len = 3'd0;
            end
            if (!ok || s.ctl.run_len >= run_cap(cls)) begin
                s.ctl.err = 1'b1;
            end
            else begin
                if (cls == RC_DIGIT) begin
                    if (s.ctl.run_len == 3'd0) begin
                        s.ctl.hex     = {12'h000, hv};
                        s.ctl.dec     = {4'h0, dv};
                        s.ctl.dec_bad = !is_dec;
                    end
                    else begin
                        s.ctl.hex = {s.ctl.hex[11:0], hv};
                        if (!is_dec || s.ctl.dec == 8'd0) begin
                            s.ctl.dec_bad = 1'b1;
                        end
                        else if (!s.ctl.dec_bad) begin
                            dmul = 12'(s.ctl.dec) * 12'd10 + 12'(dv);
                            if (dmul > 12'(OCTET_MAX)) begin
                                s.ctl.dec_bad = 1'b1;
                            end
                            s.ctl.dec = dmul[7:0];
                        end
                    end
                end
                s.ctl.run_class = cls;
                s.ctl.run_len   = s.ctl.run_len + 3'd1;
            end
        end
        return s;
    endfunction

endpackage

// File: src/ip6ap_char_if.sv
// Character channel: one text character per item with a last-character mark.
interface ip6ap_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: src/ip6ap_addr_if.sv
// Address channel: ok flag and eight 16-bit groups per item.
interface ip6ap_addr_if;
    logic        valid;
    logic        ready;
    logic        addr_ok;
    logic [15:0] group_0;
    logic [15:0] group_1;
    logic [15:0] group_2;
    logic [15:0] group_3;
    logic [15:0] group_4;
    logic [15:0] group_5;
    logic [15:0] group_6;
    logic [15:0] group_7;

    modport source (output valid, output addr_ok,
                    output group_0, output group_1, output group_2, output group_3,
                    output group_4, output group_5, output group_6, output group_7,
                    input ready);
    modport sink   (input valid, input addr_ok,
                    input group_0, input group_1, input group_2, input group_3,
                    input group_4, input group_5, input group_6, input group_7,
                    output ready);
endinterface

// File: src/ip6ap_scan.sv
// Input register and per-character parser state; snapshots the state on the last character.
module ip6ap_scan (
    input  logic               clk,
    input  logic               rst_n,
    ip6ap_char_if.sink         chars,
    output logic               snap_valid,
    output ip6ap_pkg::pstate_t snap,
    input  logic               snap_ready
);

    logic               in_valid_reg;
    logic [7:0]         char_reg;
    logic               last_reg;
    ip6ap_pkg::ctl_t    ctl_reg;
    ip6ap_pkg::grp_t    grp_reg;
    logic               snap_valid_reg;
    ip6ap_pkg::pstate_t snap_reg;

    ip6ap_pkg::pstate_t cur;
    ip6ap_pkg::pstate_t nxt;
    logic               snap_free;
    logic               go;

    assign cur.ctl   = ctl_reg;
    assign cur.grp   = grp_reg;
    assign nxt       = ctl_reg.err ? cur : ip6ap_pkg::take_char(cur, char_reg);
    assign snap_free = !snap_valid_reg || snap_ready;
    assign go        = in_valid_reg && (!last_reg || snap_free);

    assign chars.ready = !in_valid_reg || go;
    assign snap_valid  = snap_valid_reg;
    assign snap        = snap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            ctl_reg        <= ip6ap_pkg::CTL_RESET;
        end
        else begin
            if (chars.ready) begin
                in_valid_reg <= chars.valid;
            end
            if (go && last_reg) begin
                snap_valid_reg <= 1'b1;
            end
            else if (snap_ready) begin
                snap_valid_reg <= 1'b0;
            end
            if (go) begin
                ctl_reg <= last_reg ? ip6ap_pkg::CTL_RESET : nxt.ctl;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready) begin
            char_reg <= chars.char_code;
            last_reg <= chars.last_char;
        end
        if (go) begin
            grp_reg <= nxt.grp;
        end
        if (go && last_reg) begin
            snap_reg <= nxt;
        end
    end

endmodule

// File: src/ip6ap_finish.sv
// End-of-string checks, address assembly and result register.
module ip6ap_finish (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               snap_valid,
    input  ip6ap_pkg::pstate_t snap,
    output logic               snap_ready,
    ip6ap_addr_if.source       addr
);

    logic            res_valid_reg;
    ip6ap_pkg::res_t res_reg;
    ip6ap_pkg::res_t res_next;

    function automatic ip6ap_pkg::res_t fin_result(ip6ap_pkg::pstate_t s);
        ip6ap_pkg::step_t   r;
        ip6ap_pkg::pstate_t t;
        ip6ap_pkg::res_t    o;
        logic               ok;
        logic [4:0]         pos;
        t = s;
        ok = !t.ctl.err;
        if (ok && t.ctl.run_len != 3'd0) begin
            r  = ip6ap_pkg::close_run(t);
            t  = r.st;
            ok = r.ok;
        end
        if (ok) begin
            if (t.ctl.prev == ip6ap_pkg::TK_RALIGN) begin
                ok = t.ctl.lcnt < ip6ap_pkg::NUM_GROUPS;
            end
            else if (t.ctl.prev != ip6ap_pkg::TK_NUM ||
                     (t.ctl.dotted != 3'd0 &&
                      t.ctl.dotted != ip6ap_pkg::DOTTED_MAX - 3'd1)) begin
                ok = 1'b0;
            end
            else begin
                if (t.ctl.dotted != 3'd0) begin
                    t.ctl.dotted = t.ctl.dotted + 3'd1;
                end
                r  = ip6ap_pkg::write_num(t);
                t  = r.st;
                ok = r.ok &&
                     !((!t.ctl.comp && t.ctl.lcnt != ip6ap_pkg::NUM_GROUPS) ||
                       (5'(t.ctl.lcnt) + 5'(t.ctl.rcnt)) > 5'(ip6ap_pkg::NUM_GROUPS));
            end
        end
        o.ok = ok;
        for (int i = 0; i < 8; i++) begin
            pos = 5'(i) + 5'(t.ctl.rcnt);
            o.grp[3'(i)] = 16'h0000;
            if (ok) begin
                if (4'(i) < t.ctl.lcnt) begin
                    o.grp[3'(i)] = t.grp.left[3'(i)];
                end
                else if (pos >= 5'(ip6ap_pkg::NUM_GROUPS)) begin
                    o.grp[3'(i)] = t.grp.right[pos[2:0]];
                end
            end
        end
        return o;
    endfunction

    assign res_next   = fin_result(snap);
    assign snap_ready = !res_valid_reg || addr.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end
        else if (snap_ready) begin
            res_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_valid && snap_ready) begin
            res_reg <= res_next;
        end
    end

    assign addr.valid   = res_valid_reg;
    assign addr.addr_ok = res_reg.ok;
    assign addr.group_0 = res_reg.grp[0];
    assign addr.group_1 = res_reg.grp[1];
    assign addr.group_2 = res_reg.grp[2];
    assign addr.group_3 = res_reg.grp[3];
    assign addr.group_4 = res_reg.grp[4];
    assign addr.group_5 = res_reg.grp[5];
    assign addr.group_6 = res_reg.grp[6];
    assign addr.group_7 = res_reg.grp[7];

endmodule

// File: src/ipv6_text_address_parser_top.sv
// IPv6 text address parser, one character per item.
// Throughput: one character per cycle unless addr stalls; one address item per string.
// Path: after its last character is accepted, the address item passes the input register,
// the parser state with its end snapshot and the result register before it is offered.
// rst_n clears all valid flags and the parser control state asynchronously;
// the group stores are not cleared.
module ipv6_text_address_parser_top (
    input  logic         clk,
    input  logic         rst_n,
    ip6ap_char_if.sink   chars,
    ip6ap_addr_if.source addr
);

    logic               snap_valid;
    logic               snap_ready;
    ip6ap_pkg::pstate_t snap;

    ip6ap_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready)
    );

    ip6ap_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready),
        .addr       (addr)
    );

endmodule

// File: tb/ip6ap_parse_checker.sv
`timescale 1ns / 100ps
// Checker for the IPv6 text parser: predicts address items from accepted characters and compares.
module ip6ap_parse_checker (
    input  logic  clk,
    input  logic  rst_n,
    ip6ap_char_if chars,
    ip6ap_addr_if addr,
    output int    fail_count,
    output int    pending
);

    typedef struct packed {
        logic             ok;
        logic [7:0][15:0] grp;
    } addr_word_t;

    addr_word_t expected_addrs[$];
    int fails = 0;
    int waiting = 0;

    ip6ap_pkg::run_class_t run_cls;
    logic [2:0]            run_len;
    logic [15:0]           hex_acc;
    logic [11:0]           dec_acc;
    logic                  dec_bad;
    ip6ap_pkg::token_t     prev_tok;
    logic                  compressed;
    logic [15:0]           left_grp [8];
    logic [15:0]           right_grp [8];
    logic [3:0]            left_cnt;
    logic [3:0]            right_cnt;
    logic [2:0]            dotted;
    logic                  parse_err;

    assign fail_count = fails;
    assign pending    = waiting;

    function automatic void clear_parser();
        run_cls    = ip6ap_pkg::RC_NONE;
        run_len    = 3'd0;
        hex_acc    = 16'd0;
        dec_acc    = 12'd0;
        dec_bad    = 1'b0;
        prev_tok   = ip6ap_pkg::TK_START;
        compressed = 1'b0;
        for (int i = 0; i < 8; i++) begin
            left_grp[3'(i)]  = 16'd0;
            right_grp[3'(i)] = 16'd0;
        end
        left_cnt  = 4'd0;
        right_cnt = 4'd0;
        dotted    = 3'd0;
        parse_err = 1'b0;
    endfunction

    function automatic logic [2:0] run_limit(ip6ap_pkg::run_class_t cls);
        case (cls)
            ip6ap_pkg::RC_DIGIT: return 3'd4;
            ip6ap_pkg::RC_COLON: return 3'd2;
            ip6ap_pkg::RC_DOT:   return 3'd1;
            default:             return 3'd0;
        endcase
    endfunction

    function automatic logic store_group(logic [15:0] v);
        if (5'(left_cnt) + 5'(right_cnt) >= 5'(ip6ap_pkg::NUM_GROUPS))
            return 1'b0;
        if (compressed) begin
            right_grp[right_cnt[2:0]] = v;
            right_cnt = right_cnt + 4'd1;
        end
        else begin
            left_grp[left_cnt[2:0]] = v;
            left_cnt = left_cnt + 4'd1;
        end
        return 1'b1;
    endfunction

    // second octet of a pair merges into the group opened by the first
    function automatic logic store_octet();
        logic [2:0] idx;
        if (dec_bad || dec_acc > 12'(ip6ap_pkg::OCTET_MAX))
            return 1'b0;
        if (dotted[0])
            return store_group({dec_acc[7:0], 8'h00});
        if (compressed) begin
            if (right_cnt == 4'd0)
                return 1'b0;
            idx = 3'(right_cnt - 4'd1);
            right_grp[idx] = right_grp[idx] | {8'h00, dec_acc[7:0]};
        end
        else begin
            if (left_cnt == 4'd0)
                return 1'b0;
            idx = 3'(left_cnt - 4'd1);
            left_grp[idx] = left_grp[idx] | {8'h00, dec_acc[7:0]};
        end
        return 1'b1;
    endfunction

    function automatic logic commit_number();
        if (dotted != 3'd0)
            return store_octet();
        return store_group(hex_acc);
    endfunction

    function automatic logic close_token();
        ip6ap_pkg::token_t tok;
        logic              ok;
        ok = 1'b1;
        case (run_cls)
            ip6ap_pkg::RC_DIGIT:
            begin
                tok = ip6ap_pkg::TK_NUM;
                ok  = (prev_tok != ip6ap_pkg::TK_NUM);
            end
            ip6ap_pkg::RC_COLON:
            begin
                if (run_len == 3'd1) begin
                    tok = ip6ap_pkg::TK_SEP;
                    if (prev_tok == ip6ap_pkg::TK_NUM && dotted == 3'd0)
                        ok = commit_number();
                    else
                        ok = 1'b0;
                end
                else begin
                    tok = ip6ap_pkg::TK_RALIGN;
                    if (prev_tok == ip6ap_pkg::TK_SEP || prev_tok == ip6ap_pkg::TK_SEP4 ||
                        dotted != 3'd0 || compressed) begin
                        ok = 1'b0;
                    end
                    else begin
                        if (prev_tok == ip6ap_pkg::TK_NUM)
                            ok = commit_number();
                        compressed = 1'b1;
                    end
                end
            end
            ip6ap_pkg::RC_DOT:
            begin
                tok = ip6ap_pkg::TK_SEP4;
                if (prev_tok != ip6ap_pkg::TK_NUM || dotted >= ip6ap_pkg::DOTTED_MAX) begin
                    ok = 1'b0;
                end
                else begin
                    dotted = dotted + 3'd1;
                    ok     = commit_number();
                end
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        prev_tok = tok;
        return ok;
    endfunction

    function automatic void feed_char(logic [7:0] c);
        ip6ap_pkg::run_class_t cls;
        logic [3:0]            hv;
        logic [3:0]            dv;
        logic                  is_dec;
        cls    = ip6ap_pkg::RC_NONE;
        hv     = 4'd0;
        dv     = 4'd0;
        is_dec = 1'b0;
        if (c >= ip6ap_pkg::CH_DIGIT_LO && c <= ip6ap_pkg::CH_DIGIT_HI) begin
            cls    = ip6ap_pkg::RC_DIGIT;
            hv     = 4'(c - ip6ap_pkg::CH_DIGIT_LO);
            dv     = hv;
            is_dec = 1'b1;
        end
        else if (c >= ip6ap_pkg::CH_LOWER_LO && c <= ip6ap_pkg::CH_LOWER_HI) begin
            cls = ip6ap_pkg::RC_DIGIT;
            hv  = 4'(c - ip6ap_pkg::CH_LOWER_LO + 8'd10);
        end
        else if (c >= ip6ap_pkg::CH_UPPER_LO && c <= ip6ap_pkg::CH_UPPER_HI) begin
            cls = ip6ap_pkg::RC_DIGIT;
            hv  = 4'(c - ip6ap_pkg::CH_UPPER_LO + 8'd10);
        end
        else if (c == ip6ap_pkg::CH_COLON) begin
            cls = ip6ap_pkg::RC_COLON;
        end
        else if (c == ip6ap_pkg::CH_DOT) begin
            cls = ip6ap_pkg::RC_DOT;
        end

        if (cls == ip6ap_pkg::RC_NONE) begin
            parse_err = 1'b1;
            return;
        end
        if (run_len != 3'd0 && run_cls != cls) begin
            if (!close_token()) begin
                parse_err = 1'b1;
                return;
            end
            run_len = 3'd0;
        end
        if (run_len >= run_limit(cls)) begin
            parse_err = 1'b1;
            return;
        end
        if (cls == ip6ap_pkg::RC_DIGIT) begin
            if (run_len == 3'd0) begin
                hex_acc = {12'h000, hv};
                dec_acc = {8'h00, dv};
                dec_bad = !is_dec;
            end
            else begin
                hex_acc = {hex_acc[11:0], hv};
                if (!is_dec || dec_acc == 12'd0) begin
                    dec_bad = 1'b1;
                end
                else if (!dec_bad) begin
                    dec_acc = dec_acc * 12'd10 + 12'(dv);
                    if (dec_acc > 12'(ip6ap_pkg::OCTET_MAX))
                        dec_bad = 1'b1;
                end
            end
        end
        run_cls = cls;
        run_len = run_len + 3'd1;
    endfunction

    function automatic logic end_of_address();
        if (prev_tok == ip6ap_pkg::TK_RALIGN)
            return left_cnt < ip6ap_pkg::NUM_GROUPS;
        if (prev_tok != ip6ap_pkg::TK_NUM || (dotted != 3'd0 && dotted != 3'd3))
            return 1'b0;
        if (dotted != 3'd0)
            dotted = dotted + 3'd1;
        if (!commit_number())
            return 1'b0;
        if ((!compressed && left_cnt != ip6ap_pkg::NUM_GROUPS) ||
            5'(left_cnt) + 5'(right_cnt) > 5'(ip6ap_pkg::NUM_GROUPS))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic parse_step(logic [7:0] c, logic last, output addr_word_t res);
        logic        ok;
        logic [15:0] g;
        res = '0;
        if (!parse_err)
            feed_char(c);
        if (!last)
            return 1'b0;
        ok = !parse_err;
        if (ok && run_len != 3'd0)
            ok = close_token();
        if (ok)
            ok = end_of_address();
        res.ok = ok;
        for (int i = 0; i < 8; i++) begin
            g = 16'd0;
            if (ok) begin
                if (i < int'(left_cnt))
                    g = left_grp[3'(i)];
                else if (i + int'(right_cnt) >= 8)
                    g = right_grp[3'(i + int'(right_cnt) - 8)];
            end
            res.grp[3'(i)] = g;
        end
        clear_parser();
        return 1'b1;
    endfunction

    function automatic void note_mismatch(string field, logic [15:0] want, logic [15:0] got);
        fails++;
        if (fails <= 10)
            $display("mismatch at %0t: %s expected %h got %h", $time, field, want, got);
    endfunction

    always @(posedge clk) begin
        addr_word_t want;
        addr_word_t got;
        if (!rst_n) begin
            clear_parser();
        end
        else begin
            if (addr.valid && addr.ready) begin
                got.ok     = addr.addr_ok;
                got.grp[0] = addr.group_0;
                got.grp[1] = addr.group_1;
                got.grp[2] = addr.group_2;
                got.grp[3] = addr.group_3;
                got.grp[4] = addr.group_4;
                got.grp[5] = addr.group_5;
                got.grp[6] = addr.group_6;
                got.grp[7] = addr.group_7;
                if (expected_addrs.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected address item at %0t: ok %b groups %h",
                                 $time, got.ok, got.grp);
                end
                else begin
                    want = expected_addrs.pop_front();
                    if (want.ok !== got.ok)
                        note_mismatch("addr_ok", 16'(want.ok), 16'(got.ok));
                    for (int i = 0; i < 8; i++) begin
                        if (want.grp[3'(i)] !== got.grp[3'(i)])
                            note_mismatch($sformatf("group_%0d", i), want.grp[3'(i)],
                                          got.grp[3'(i)]);
                    end
                end
            end
            if (chars.valid && chars.ready) begin
                if (parse_step(chars.char_code, chars.last_char, want))
                    expected_addrs.push_back(want);
            end
        end
        waiting = expected_addrs.size();
    end

endmodule

// File: tb/tb_ipv6_text_address_parser_top.sv
`timescale 1ns / 100ps
// Testbench top for the IPv6 text parser: character stimulus, receiver stalls and verdict.
module tb_ipv6_text_address_parser_top;

    localparam int CHAR_TARGET  = 750;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycles = 0;

    logic [7:0] text[$];
    int         chars_sent   = 0;
    int         strings_sent = 0;
    bit         send_burst   = 1'b0;
    bit         recv_burst   = 1'b0;

    ip6ap_char_if chars_bus();
    ip6ap_addr_if addr_bus();

    ipv6_text_address_parser_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_bus),
        .addr  (addr_bus)
    );

    ip6ap_parse_checker parse_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars_bus),
        .addr       (addr_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_text_char();
        string pool;
        pool = "0129afAF::..xG /";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic logic [7:0] hex_char(int d);
        if (d < 10)
            return ip6ap_pkg::CH_DIGIT_LO + 8'(d);
        if ($urandom_range(0, 1) != 0)
            return ip6ap_pkg::CH_UPPER_LO + 8'(d - 10);
        return ip6ap_pkg::CH_LOWER_LO + 8'(d - 10);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endfunction

    function automatic void add_hex_group();
        int r;
        int nd;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            add_text("ffFF");
        end
        else if (r < 16) begin
            add_text("0");
        end
        else begin
            nd = $urandom_range(1, 4);
            for (int i = 0; i < nd; i++)
                text.push_back(hex_char($urandom_range(0, 15)));
        end
    endfunction

    function automatic void add_group_list(int n);
        for (int i = 0; i < n; i++) begin
            if (i > 0)
                text.push_back(ip6ap_pkg::CH_COLON);
            add_hex_group();
        end
    endfunction

    function automatic void add_dotted_tail();
        int r;
        int v;
        for (int i = 0; i < 4; i++) begin
            if (i > 0)
                text.push_back(ip6ap_pkg::CH_DOT);
            r = $urandom_range(0, 99);
            if (r < 15)
                v = 0;
            else if (r < 30)
                v = 255;
            else
                v = $urandom_range(0, 255);
            add_text($sformatf("%0d", v));
        end
    endfunction

    function automatic void build_address();
        int  mode;
        int  room;
        int  nl;
        int  nr;
        bit  dotted_tail;
        text.delete();
        mode = $urandom_range(0, 3);
        if (mode == 0) begin
            add_group_list(8);
        end
        else if (mode == 1) begin
            add_group_list(6);
            text.push_back(ip6ap_pkg::CH_COLON);
            add_dotted_tail();
        end
        else begin
            dotted_tail = (mode == 3);
            room = dotted_tail ? 6 : 8;
            if ($urandom_range(0, 9) == 0)
                room++;
            nl = $urandom_range(0, room);
            nr = $urandom_range(0, room - nl);
            add_group_list(nl);
            add_text("::");
            add_group_list(nr);
            if (dotted_tail) begin
                if (nr > 0)
                    text.push_back(ip6ap_pkg::CH_COLON);
                add_dotted_tail();
            end
        end
    endfunction

    function automatic void break_text();
        int pos;
        pos = $urandom_range(0, text.size() - 1);
        case ($urandom_range(0, 5))
            0: text[pos] = 8'($urandom_range(0, 255));
            1: text[pos] = pick_text_char();
            2: text.delete(pos);
            3: text.insert(pos, pick_text_char());
            4: text.insert(pos, ip6ap_pkg::CH_DIGIT_LO + 8'($urandom_range(0, 9)));
            default: text.insert(pos, text[pos]);
        endcase
        if (text.size() == 0)
            text.push_back(pick_text_char());
    endfunction

    function automatic void build_noise();
        int len;
        text.delete();
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 40)
                text.push_back(8'($urandom_range(0, 255)));
            else
                text.push_back(pick_text_char());
        end
    endfunction

    task automatic send_char(logic [7:0] c, logic last);
        int gap;
        gap = send_burst ? 0 : pick_gap();
        if (gap > 0) begin
            chars_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        chars_bus.valid     <= 1'b1;
        chars_bus.char_code <= c;
        chars_bus.last_char <= last;
        @(posedge clk);
        while (!chars_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
        chars_sent += text.size();
        strings_sent++;
    endtask

    task automatic wait_idle();
        chars_bus.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic send_string(string s);
        text.delete();
        add_text(s);
        send_text();
    endtask

    task automatic send_byte(logic [7:0] c);
        text.delete();
        text.push_back(c);
        send_text();
    endtask

    initial begin
        int stall;
        stall = 0;
        addr_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                addr_bus.ready <= 1'b0;
                stall--;
            end
            else begin
                addr_bus.ready <= 1'b1;
                if (!recv_burst && $urandom_range(0, 99) < 20)
                    stall = pick_gap();
            end
        end
    end

    initial begin
        int r;
        chars_bus.valid     = 1'b0;
        chars_bus.char_code = 8'h00;
        chars_bus.last_char = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty compression, out-of-set bytes, latched error, long runs, dotted tail
        send_string("::");
        send_byte(8'h00);
        send_byte(8'hff);
        send_string("G::");
        send_string("fFfF0");
        send_string(":::");
        send_string("::0.9.255.1");
        wait_idle();

        while (chars_sent < CHAR_TARGET) begin
            send_burst = ($urandom_range(0, 5) == 0);
            recv_burst = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            if (r < 15) begin
                build_noise();
            end
            else begin
                build_address();
                if (r < 40)
                    break_text();
                if (r < 25)
                    break_text();
            end
            send_text();
            if ($urandom_range(0, 9) == 0)
                wait_idle();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
